@@ hdl/bosc_pkg.sv @@
// shared types and constants for the bond order solid classifier
package bosc_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int MAX_NEIGHBORS = 64;
  localparam int ACC_W         = 40;
  localparam int MUL_STEPS     = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = FRAC_BITS;
  localparam int MEAN_STEPS    = 22;

  localparam logic [2:0] REG_BOND_THR  = 3'd0;
  localparam logic [2:0] REG_AVG_THR   = 3'd1;
  localparam logic [2:0] REG_MIN_BONDS = 3'd2;
  localparam logic [2:0] REG_CMP_BELOW = 3'd3;
  localparam logic [2:0] REG_FRAC_RULE = 3'd4;

  typedef struct packed {
    logic signed [15:0] real_i;
    logic signed [15:0] imag_i;
    logic signed [15:0] real_j;
    logic signed [15:0] imag_j;
    logic               last_component;
    logic               last_bond;
  } comp_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] bond_value;
    logic               bond_connected;
    logic               zero_norm;
    logic [6:0]         bond_count;
    logic signed [15:0] avg_value;
    logic               is_solid;
    logic               last;
  } res_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_PROD,
    ST_CMP,
    ST_DIV,
    ST_BOND,
    ST_MEAN,
    ST_ATOM
  } state_t;

endpackage

@@ hdl/bond_order_solid_classifier.sv @@
// bond order solid classifier: serial accumulate, square roots, divide and atom mean
// a component word is accepted, then runs 16 shift-add multiply steps and an accumulate
// a bond's last component adds 32 square root steps, product, compare and up to 14
// quotient steps before its bond word; an atom's last bond adds 22 mean divide steps
// one word is worked on at a time; the result register frees the input side
// rst is synchronous: accumulators, counts, control and registers go to reset values
module bond_order_solid_classifier (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  comp_valid,
  output logic                  comp_stall,
  input  bosc_pkg::comp_word_t  comp,
  output logic                  res_valid,
  input  logic                  res_stall,
  output bosc_pkg::res_word_t   res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic signed [40:0] ACC_MAX = 41'sh7F_FFFF_FFFF;
  localparam logic signed [40:0] ACC_MIN = -ACC_MAX - 41'sd1;

  bosc_pkg::state_t state, state_next;

  // configuration
  logic signed [15:0] bond_thr, avg_thr;
  logic [15:0]        min_bonds;
  logic               cmp_below, frac_rule;

  // accumulators and atom counts
  logic [39:0]        ni, nj;
  logic signed [39:0] dot;
  logic [6:0]         cc, nc;
  logic signed [21:0] bsum;

  logic [5:0]         cnt;
  logic               lc, lb;

  // serial multiply
  logic signed [31:0] a_ri, a_ii, a_rj, a_ij;
  logic [15:0]        b_ri, b_ii, b_rj, b_ij;
  logic signed [33:0] t_ni, t_nj, t_dot;

  // square roots and divide
  logic [63:0]        sv_i, sv_j;
  logic [34:0]        srem_i, srem_j;
  logic [31:0]        sroot_i, sroot_j;
  logic               zero, dneg;
  logic [39:0]        dmag;
  logic [63:0]        den;
  logic [64:0]        qrem;
  logic [14:0]        q;

  // mean divide
  logic [21:0]        mmag, mq;
  logic [7:0]         mrem;
  logic               mneg;

  logic free;
  assign free = !res_valid || !res_stall;
  assign comp_stall = (state != bosc_pkg::ST_IDLE);
  assign pready = 1'b1;

  function automatic logic signed [33:0] pp(input logic signed [31:0] a, input logic b,
                                            input logic neg);
    logic signed [33:0] e;
    e = {{2{a[31]}}, a};
    if (!b) return '0;
    return neg ? -e : e;
  endfunction

  logic mul_neg;
  assign mul_neg = (cnt == 6'(bosc_pkg::MUL_STEPS - 1));

  // accumulate with saturation
  logic signed [40:0] ni_sum, nj_sum, dot_sum;
  logic [39:0]        ni_new, nj_new;
  logic signed [39:0] dot_new;
  always_comb begin
    ni_sum  = $signed({1'b0, ni}) + $signed({7'b0, t_ni});
    nj_sum  = $signed({1'b0, nj}) + $signed({7'b0, t_nj});
    dot_sum = $signed({dot[39], dot}) + $signed({{7{t_dot[33]}}, t_dot});
    ni_new  = (ni_sum > ACC_MAX) ? ACC_MAX[39:0] : ni_sum[39:0];
    nj_new  = (nj_sum > ACC_MAX) ? ACC_MAX[39:0] : nj_sum[39:0];
    if (dot_sum > ACC_MAX) begin
      dot_new = ACC_MAX[39:0];
    end else if (dot_sum < ACC_MIN) begin
      dot_new = ACC_MIN[39:0];
    end else begin
      dot_new = dot_sum[39:0];
    end
  end

  // one root digit per cycle
  logic [36:0] rt_i, rt_j, tr_i, tr_j;
  assign rt_i = {srem_i, sv_i[63:62]};
  assign rt_j = {srem_j, sv_j[63:62]};
  assign tr_i = {3'b0, sroot_i, 2'b01};
  assign tr_j = {3'b0, sroot_j, 2'b01};

  logic [64:0] qr2;
  assign qr2 = {qrem[63:0], 1'b0};

  // bond value and atom bookkeeping
  logic signed [15:0] val;
  logic               conn, room;
  logic [6:0]         cc_new, nc_new;
  logic signed [21:0] bsum_new;
  always_comb begin
    val  = dneg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    conn = cmp_below ? (val < bond_thr) : (val > bond_thr);
    room = (nc < 7'(bosc_pkg::MAX_NEIGHBORS));
    cc_new   = (room && conn) ? cc + 7'd1 : cc;
    nc_new   = room ? nc + 7'd1 : nc;
    bsum_new = room ? bsum + 22'(val) : bsum;
  end

  logic [7:0] mr2;
  assign mr2 = {mrem[6:0], mmag[21]};

  logic signed [15:0] avg;
  logic [22:0]        frac_rhs;
  logic               count_ok, solid;
  always_comb begin
    avg = (nc == 7'd0) ? 16'sd0 : (mneg ? -$signed(mq[15:0]) : $signed(mq[15:0]));
    frac_rhs = min_bonds * nc;
    count_ok = frac_rule ? ({8'b0, cc, 8'b0} > frac_rhs)
                         : ({2'b0, cc, 8'b0} > {1'b0, min_bonds});
    solid = count_ok && (cmp_below ? (avg < avg_thr) : (avg > avg_thr));
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      bond_thr  <= 16'sd8192;
      avg_thr   <= 16'sd8192;
      min_bonds <= 16'd1792;
      cmp_below <= 1'b0;
      frac_rule <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        bosc_pkg::REG_BOND_THR:  bond_thr  <= pwdata[15:0];
        bosc_pkg::REG_AVG_THR:   avg_thr   <= pwdata[15:0];
        bosc_pkg::REG_MIN_BONDS: min_bonds <= pwdata[15:0];
        bosc_pkg::REG_CMP_BELOW: cmp_below <= pwdata[0];
        bosc_pkg::REG_FRAC_RULE: frac_rule <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      bosc_pkg::REG_BOND_THR:  prdata = {16'b0, bond_thr};
      bosc_pkg::REG_AVG_THR:   prdata = {16'b0, avg_thr};
      bosc_pkg::REG_MIN_BONDS: prdata = {16'b0, min_bonds};
      bosc_pkg::REG_CMP_BELOW: prdata = {31'b0, cmp_below};
      bosc_pkg::REG_FRAC_RULE: prdata = {31'b0, frac_rule};
      default:                 prdata = '0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bosc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bosc_pkg::ST_IDLE: if (comp_valid) state_next = bosc_pkg::ST_MUL;
      bosc_pkg::ST_MUL:  if (mul_neg) state_next = bosc_pkg::ST_ACC;
      bosc_pkg::ST_ACC:  state_next = lc ? bosc_pkg::ST_SQRT : bosc_pkg::ST_IDLE;
      bosc_pkg::ST_SQRT: begin
        if (cnt == 6'(bosc_pkg::SQRT_STEPS - 1)) state_next = bosc_pkg::ST_PROD;
      end
      bosc_pkg::ST_PROD: state_next = bosc_pkg::ST_CMP;
      bosc_pkg::ST_CMP: begin
        if (zero || {dmag, 24'b0} >= den) begin
          state_next = bosc_pkg::ST_BOND;
        end else begin
          state_next = bosc_pkg::ST_DIV;
        end
      end
      bosc_pkg::ST_DIV: begin
        if (cnt == 6'(bosc_pkg::DIV_STEPS - 1)) state_next = bosc_pkg::ST_BOND;
      end
      bosc_pkg::ST_BOND: begin
        if (free) state_next = lb ? bosc_pkg::ST_MEAN : bosc_pkg::ST_IDLE;
      end
      bosc_pkg::ST_MEAN: begin
        if (cnt == 6'(bosc_pkg::MEAN_STEPS - 1)) state_next = bosc_pkg::ST_ATOM;
      end
      bosc_pkg::ST_ATOM: if (free) state_next = bosc_pkg::ST_IDLE;
      default: state_next = bosc_pkg::ST_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == bosc_pkg::ST_BOND && free) begin
      res_valid <= 1'b1;
    end else if (state == bosc_pkg::ST_ATOM && free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bosc_pkg::ST_BOND && free) begin
      res <= '0;
      res.bond_value     <= zero ? 16'sd0 : val;
      res.bond_connected <= conn;
      res.zero_norm      <= zero;
      res.last           <= !lb;
    end else if (state == bosc_pkg::ST_ATOM && free) begin
      res <= '0;
      res.result_kind <= 1'b1;
      res.bond_count  <= cc;
      res.avg_value   <= avg;
      res.is_solid    <= solid;
      res.last        <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ni   <= '0;
      nj   <= '0;
      dot  <= '0;
      cc   <= '0;
      nc   <= '0;
      bsum <= '0;
      cnt  <= '0;
    end else begin
      case (state)
        bosc_pkg::ST_IDLE: begin
          if (comp_valid) begin
            a_ri  <= 32'(comp.real_i);
            a_ii  <= 32'(comp.imag_i);
            a_rj  <= 32'(comp.real_j);
            a_ij  <= 32'(comp.imag_j);
            b_ri  <= comp.real_i;
            b_ii  <= comp.imag_i;
            b_rj  <= comp.real_j;
            b_ij  <= comp.imag_j;
            lc    <= comp.last_component;
            lb    <= comp.last_bond;
            t_ni  <= '0;
            t_nj  <= '0;
            t_dot <= '0;
            cnt   <= '0;
          end
        end
        bosc_pkg::ST_MUL: begin
          t_ni  <= t_ni + pp(a_ri, b_ri[0], mul_neg) + pp(a_ii, b_ii[0], mul_neg);
          t_nj  <= t_nj + pp(a_rj, b_rj[0], mul_neg) + pp(a_ij, b_ij[0], mul_neg);
          t_dot <= t_dot + pp(a_ri, b_rj[0], mul_neg) + pp(a_ii, b_ij[0], mul_neg);
          a_ri  <= a_ri <<< 1;
          a_ii  <= a_ii <<< 1;
          a_rj  <= a_rj <<< 1;
          a_ij  <= a_ij <<< 1;
          b_ri  <= b_ri >> 1;
          b_ii  <= b_ii >> 1;
          b_rj  <= b_rj >> 1;
          b_ij  <= b_ij >> 1;
          cnt   <= mul_neg ? 6'd0 : cnt + 6'd1;
        end
        bosc_pkg::ST_ACC: begin
          if (lc) begin
            ni      <= '0;
            nj      <= '0;
            dot     <= '0;
            zero    <= (ni_new == 40'd0) || (nj_new == 40'd0);
            dneg    <= dot_new[39];
            dmag    <= dot_new[39] ? 40'(-dot_new) : 40'(dot_new);
            sv_i    <= {1'b0, ni_new[38:0], 24'b0};
            sv_j    <= {1'b0, nj_new[38:0], 24'b0};
            srem_i  <= '0;
            srem_j  <= '0;
            sroot_i <= '0;
            sroot_j <= '0;
            cnt     <= '0;
          end else begin
            ni  <= ni_new;
            nj  <= nj_new;
            dot <= dot_new;
          end
        end
        bosc_pkg::ST_SQRT: begin
          if (rt_i >= tr_i) begin
            srem_i  <= 35'(rt_i - tr_i);
            sroot_i <= {sroot_i[30:0], 1'b1};
          end else begin
            srem_i  <= rt_i[34:0];
            sroot_i <= {sroot_i[30:0], 1'b0};
          end
          if (rt_j >= tr_j) begin
            srem_j  <= 35'(rt_j - tr_j);
            sroot_j <= {sroot_j[30:0], 1'b1};
          end else begin
            srem_j  <= rt_j[34:0];
            sroot_j <= {sroot_j[30:0], 1'b0};
          end
          sv_i <= sv_i << 2;
          sv_j <= sv_j << 2;
          cnt  <= (cnt == 6'(bosc_pkg::SQRT_STEPS - 1)) ? 6'd0 : cnt + 6'd1;
        end
        bosc_pkg::ST_PROD: begin
          den <= sroot_i * sroot_j;
        end
        bosc_pkg::ST_CMP: begin
          qrem <= {1'b0, dmag, 24'b0};
          cnt  <= '0;
          if (zero) begin
            q <= '0;
          end else if ({dmag, 24'b0} >= den) begin
            q <= 15'(1 << bosc_pkg::FRAC_BITS);
          end else begin
            q <= '0;
          end
        end
        bosc_pkg::ST_DIV: begin
          if (qr2 >= {1'b0, den}) begin
            qrem <= qr2 - {1'b0, den};
            q    <= {q[13:0], 1'b1};
          end else begin
            qrem <= qr2;
            q    <= {q[13:0], 1'b0};
          end
          cnt <= (cnt == 6'(bosc_pkg::DIV_STEPS - 1)) ? 6'd0 : cnt + 6'd1;
        end
        bosc_pkg::ST_BOND: begin
          if (free) begin
            cc   <= cc_new;
            nc   <= nc_new;
            bsum <= bsum_new;
            mneg <= bsum_new[21];
            mmag <= bsum_new[21] ? 22'(-bsum_new) : 22'(bsum_new);
            mrem <= '0;
            mq   <= '0;
            cnt  <= '0;
          end
        end
        bosc_pkg::ST_MEAN: begin
          if (mr2 >= {1'b0, nc}) begin
            mrem <= mr2 - {1'b0, nc};
            mq   <= {mq[20:0], 1'b1};
          end else begin
            mrem <= mr2;
            mq   <= {mq[20:0], 1'b0};
          end
          mmag <= mmag << 1;
          cnt  <= (cnt == 6'(bosc_pkg::MEAN_STEPS - 1)) ? 6'd0 : cnt + 6'd1;
        end
        bosc_pkg::ST_ATOM: begin
          if (free) begin
            cc   <= '0;
            nc   <= '0;
            bsum <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_nc_bound: assert property (@(posedge clk) disable iff (rst)
    nc <= 7'(bosc_pkg::MAX_NEIGHBORS))
    else $error("neighbour count past limit");

  a_atom_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind |-> res.bond_value == 16'sd0 && !res.bond_connected
      && !res.zero_norm && res.last)
    else $error("atom word carries bond fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    comp_valid && !comp_stall |=> comp_stall)
    else $error("input taken while previous word still in work");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.zero_norm |-> res.bond_value == 16'sd0)
    else $error("zero norm with nonzero bond value");
`endif

endmodule
